@@ rtl/c2d_pkg.sv @@
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared constants, types and helpers of the stride-1 valid 2-D convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

	localparam int unsigned MAX_KERNEL  = 7;
	localparam int unsigned MAX_WIDTH   = 1024;
	localparam int unsigned MAX_HEIGHT  = 4096;
	localparam int unsigned NUM_WEIGHTS = MAX_KERNEL * MAX_KERNEL;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned WIDX_W     = 6;
	localparam int unsigned KSZ_W      = 3;
	localparam int unsigned WID_W      = 11;
	localparam int unsigned HGT_W      = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	localparam int unsigned KVAL_W = $clog2(MAX_KERNEL + 1);
	localparam int unsigned SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KERNEL_SIZE  = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_WEIGHT = 1'b0,
		KIND_PIXEL  = 1'b1
	} kind_t;

	typedef struct packed {
		logic              we;
		logic              rd;
		logic [SLOT_W-1:0] bank;
		logic [COL_W-1:0]  addr;
		logic [DATA_W-1:0] wdata;
	} ls_req_t;

	function automatic logic [KVAL_W-1:0] clamp_k(input logic [KSZ_W-1:0] v);
		if (v == '0) begin
			return KVAL_W'(1);
		end else if (int'(v) > MAX_KERNEL) begin
			return KVAL_W'(MAX_KERNEL);
		end
		return KVAL_W'(v);
	endfunction

	function automatic logic [COL_W:0] clamp_w(input logic [WID_W-1:0] v);
		if (v == '0) begin
			return (COL_W+1)'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			return (COL_W+1)'(MAX_WIDTH);
		end
		return (COL_W+1)'(v);
	endfunction

	function automatic logic [ROW_W:0] clamp_h(input logic [HGT_W-1:0] v);
		if (v == '0) begin
			return (ROW_W+1)'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			return (ROW_W+1)'(MAX_HEIGHT);
		end
		return (ROW_W+1)'(v);
	endfunction

endpackage

`default_nettype wire

@@ rtl/c2d_if.sv @@
// ----------------------------------------------------------------------------
// c2d_stream_if / c2d_result_if
// Valid/ready channels for input items and for convolution results.
// ----------------------------------------------------------------------------
`default_nettype none

interface c2d_stream_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [c2d_pkg::WIDX_W-1:0]  weight_index;
	logic [c2d_pkg::DATA_W-1:0]  item_value;

	modport source (output valid, kind, weight_index, item_value, input ready);
	modport sink   (input valid, kind, weight_index, item_value, output ready);
endinterface

interface c2d_result_if;
	logic                        valid;
	logic                        ready;
	logic [c2d_pkg::DATA_W-1:0]  conv_sum;
	logic [c2d_pkg::ROW_W-1:0]   out_row;
	logic [c2d_pkg::COL_W-1:0]   out_col;
	logic                        last_result;

	modport source (output valid, conv_sum, out_row, out_col, last_result, input ready);
	modport sink   (input valid, conv_sum, out_row, out_col, last_result, output ready);
endinterface

`default_nettype wire

@@ rtl/c2d_line_store.sv @@
// ----------------------------------------------------------------------------
// c2d_line_store
// Row buffer: one bank per kernel row slot, all banks read at one column.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_line_store (
	input  logic                                                  clk,
	input  c2d_pkg::ls_req_t                                      req,
	output logic [c2d_pkg::MAX_KERNEL-1:0][c2d_pkg::DATA_W-1:0]   rdata
);

	for (genvar b = 0; b < c2d_pkg::MAX_KERNEL; b++) begin : g_bank
		logic [c2d_pkg::DATA_W-1:0] mem [c2d_pkg::MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (req.we && req.bank == c2d_pkg::SLOT_W'(b)) begin
				mem[req.addr] <= req.wdata;
			end
			if (req.rd) begin
				rdata[b] <= mem[req.addr];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/conv2d_valid_stride1_core.sv @@
// ----------------------------------------------------------------------------
// conv2d_valid_stride1_core
// Stride-1 valid 2-D convolution over a raster stream of 32-bit pixels.
// ----------------------------------------------------------------------------
// Takes one item (weight load or pixel) per clock while the result side keeps
// up. A result passes stages s1-s4 and then the output register. The line
// store is read at the pixel's column in all row banks and written in the same
// cycle. The 49 window multipliers, one per window position, feed a two-level
// registered adder tree. A result that is not taken moves into a one-entry
// holding register and the pipeline keeps moving. stream.ready falls only
// while that register is full, and then the whole pipeline holds. Weights are
// written in item order at the multiply stage, so loads between pixels act on
// exactly the pixels that follow. Window positions outside the kernel in use
// give zero products, so the line store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_valid_stride1_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	c2d_stream_if.sink                         stream,
	c2d_result_if.source                       result
);

	// configuration
	logic [c2d_pkg::KSZ_W-1:0] ksz_q;
	logic [c2d_pkg::WID_W-1:0] wid_q;
	logic [c2d_pkg::HGT_W-1:0] hgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksz_q <= c2d_pkg::KSZ_W'(3);
			wid_q <= c2d_pkg::WID_W'(1024);
			hgt_q <= c2d_pkg::HGT_W'(4096);
		end else if (cfg_we) begin
			unique case (c2d_pkg::cfg_idx_t'(cfg_index))
				c2d_pkg::CFG_KERNEL_SIZE:  ksz_q <= cfg_wdata[c2d_pkg::KSZ_W-1:0];
				c2d_pkg::CFG_IMAGE_WIDTH:  wid_q <= cfg_wdata[c2d_pkg::WID_W-1:0];
				c2d_pkg::CFG_IMAGE_HEIGHT: hgt_q <= cfg_wdata[c2d_pkg::HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 0: accept, counters, line store access
	logic out_v_q, skid_v_q;
	logic adv, acc, pix0, emit0, last0, wok0, col_end0, row_end0;
	logic [c2d_pkg::KVAL_W-1:0]   k0;
	logic [2*c2d_pkg::KVAL_W-1:0] ksq0;
	logic [c2d_pkg::COL_W:0]      w0;
	logic [c2d_pkg::ROW_W:0]      h0;
	logic [c2d_pkg::ROW_W-1:0]    row_q, orow0;
	logic [c2d_pkg::COL_W-1:0]    col_q, ocol0;
	logic [c2d_pkg::SLOT_W-1:0]   slot_q;

	assign adv          = !skid_v_q;
	assign stream.ready = adv;
	assign acc          = stream.valid && adv;
	assign pix0         = c2d_pkg::kind_t'(stream.kind) == c2d_pkg::KIND_PIXEL;
	assign k0           = c2d_pkg::clamp_k(ksz_q);
	assign w0           = c2d_pkg::clamp_w(wid_q);
	assign h0           = c2d_pkg::clamp_h(hgt_q);
	assign ksq0         = (2*c2d_pkg::KVAL_W)'(k0) * (2*c2d_pkg::KVAL_W)'(k0);
	assign wok0         = int'(stream.weight_index) < int'(ksq0);
	assign emit0        = ({1'b0, row_q} + (c2d_pkg::ROW_W+1)'(1) >= (c2d_pkg::ROW_W+1)'(k0))
	                   && ({1'b0, col_q} + (c2d_pkg::COL_W+1)'(1) >= (c2d_pkg::COL_W+1)'(k0));
	assign orow0        = row_q - c2d_pkg::ROW_W'(k0 - c2d_pkg::KVAL_W'(1));
	assign ocol0        = col_q - c2d_pkg::COL_W'(k0 - c2d_pkg::KVAL_W'(1));
	assign last0        = ({1'b0, row_q} == h0 - (c2d_pkg::ROW_W+1)'(1))
	                   && ({1'b0, col_q} == w0 - (c2d_pkg::COL_W+1)'(1));
	assign col_end0     = {1'b0, col_q} + (c2d_pkg::COL_W+1)'(1) >= w0;
	assign row_end0     = {1'b0, row_q} + (c2d_pkg::ROW_W+1)'(1) >= h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (acc && pix0) begin
			if (col_end0) begin
				col_q <= '0;
				if (row_end0) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + c2d_pkg::ROW_W'(1);
					slot_q <= (int'(slot_q) == c2d_pkg::MAX_KERNEL - 1) ? '0
					        : slot_q + c2d_pkg::SLOT_W'(1);
				end
			end else begin
				col_q <= col_q + c2d_pkg::COL_W'(1);
			end
		end
	end

	c2d_pkg::ls_req_t ls_req;
	logic [c2d_pkg::MAX_KERNEL-1:0][c2d_pkg::DATA_W-1:0] ls_rdata;

	assign ls_req.we    = acc && pix0;
	assign ls_req.rd    = acc && pix0;
	assign ls_req.bank  = slot_q;
	assign ls_req.addr  = col_q;
	assign ls_req.wdata = stream.item_value;

	c2d_line_store u_line_store (
		.clk   (clk),
		.req   (ls_req),
		.rdata (ls_rdata)
	);

	// pipeline control
	logic v_s1, v_s2, e_s3, e_s4;
	logic pix_s1, pix_s2, emit_s1, emit_s2, wok_s1, wok_s2, last_s1, last_s2, last_s3, last_s4;
	logic [c2d_pkg::DATA_W-1:0]  val_s1, val_s2;
	logic [c2d_pkg::WIDX_W-1:0]  widx_s1, widx_s2;
	logic [c2d_pkg::KVAL_W-1:0]  k_s1, k_s2;
	logic [c2d_pkg::SLOT_W-1:0]  slot_s1;
	logic [c2d_pkg::ROW_W-1:0]   orow_s1, orow_s2, orow_s3, orow_s4;
	logic [c2d_pkg::COL_W-1:0]   ocol_s1, ocol_s2, ocol_s3, ocol_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			e_s3    <= 1'b0;
			e_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			e_s3    <= v_s2 && pix_s2 && emit_s2;
			e_s4    <= e_s3;
			out_v_q <= e_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= pix0;
			emit_s1 <= emit0;
			wok_s1  <= wok0;
			last_s1 <= last0;
			val_s1  <= stream.item_value;
			widx_s1 <= stream.weight_index;
			k_s1    <= k0;
			slot_s1 <= slot_q;
			orow_s1 <= orow0;
			ocol_s1 <= ocol0;
			pix_s2  <= pix_s1;
			emit_s2 <= emit_s1;
			wok_s2  <= wok_s1;
			last_s2 <= last_s1;
			val_s2  <= val_s1;
			widx_s2 <= widx_s1;
			k_s2    <= k_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			last_s3 <= last_s2;
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
			last_s4 <= last_s3;
			orow_s4 <= orow_s3;
			ocol_s4 <= ocol_s3;
		end
	end

	// stage 1: window shift, new right column from line store
	logic [c2d_pkg::DATA_W-1:0] win_q  [c2d_pkg::MAX_KERNEL][c2d_pkg::MAX_KERNEL];
	logic [c2d_pkg::DATA_W-1:0] newcol [c2d_pkg::MAX_KERNEL];

	always_comb begin
		logic [c2d_pkg::SLOT_W+1:0] t;
		for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
			t = (c2d_pkg::SLOT_W+2)'(slot_s1) + (c2d_pkg::SLOT_W+2)'(c2d_pkg::MAX_KERNEL)
			  - (c2d_pkg::SLOT_W+2)'(int'(k_s1) - 1 - kr);
			if (int'(t) >= c2d_pkg::MAX_KERNEL) begin
				t = t - (c2d_pkg::SLOT_W+2)'(c2d_pkg::MAX_KERNEL);
			end
			if (kr < int'(k_s1) - 1) begin
				newcol[kr] = ls_rdata[t[c2d_pkg::SLOT_W-1:0]];
			end else if (kr == int'(k_s1) - 1) begin
				newcol[kr] = val_s1;
			end else begin
				newcol[kr] = win_q[kr][c2d_pkg::MAX_KERNEL-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
				for (int j = 0; j < c2d_pkg::MAX_KERNEL; j++) begin
					win_q[kr][j] <= '0;
				end
			end
		end else if (adv && v_s1 && pix_s1) begin
			for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
				for (int j = 0; j + 1 < c2d_pkg::MAX_KERNEL; j++) begin
					win_q[kr][j] <= win_q[kr][j+1];
				end
				win_q[kr][c2d_pkg::MAX_KERNEL-1] <= newcol[kr];
			end
		end
	end

	// stage 2: weight select, products, in-order weight writes
	logic [c2d_pkg::DATA_W-1:0] wgt_q  [c2d_pkg::NUM_WEIGHTS];
	logic [c2d_pkg::DATA_W-1:0] wsel   [c2d_pkg::MAX_KERNEL][c2d_pkg::MAX_KERNEL];
	logic [c2d_pkg::DATA_W-1:0] prod_s3 [c2d_pkg::MAX_KERNEL][c2d_pkg::MAX_KERNEL];

	always_ff @(posedge clk) begin
		if (adv && v_s2 && !pix_s2 && wok_s2) begin
			wgt_q[widx_s2] <= val_s2;
		end
	end

	always_comb begin
		for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
			for (int j = 0; j < c2d_pkg::MAX_KERNEL; j++) begin
				wsel[kr][j] = '0;
				for (int kk = 1; kk <= c2d_pkg::MAX_KERNEL; kk++) begin
					if (kr < kk && j + kk >= c2d_pkg::MAX_KERNEL && int'(k_s2) == kk) begin
						wsel[kr][j] = wgt_q[kr*kk + j + kk - c2d_pkg::MAX_KERNEL];
					end
				end
			end
		end
	end

	// positions outside the active kernel contribute nothing
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
				for (int j = 0; j < c2d_pkg::MAX_KERNEL; j++) begin
					prod_s3[kr][j] <= (kr < int'(k_s2) && j + int'(k_s2) >= c2d_pkg::MAX_KERNEL)
					                ? win_q[kr][j] * wsel[kr][j] : '0;
				end
			end
		end
	end

	// stage 3/4: adder tree
	logic [c2d_pkg::DATA_W-1:0] rsum_c [c2d_pkg::MAX_KERNEL];
	logic [c2d_pkg::DATA_W-1:0] rsum_s4 [c2d_pkg::MAX_KERNEL];
	logic [c2d_pkg::DATA_W-1:0] total_c, sum_q;
	logic [c2d_pkg::ROW_W-1:0]  orow_q;
	logic [c2d_pkg::COL_W-1:0]  ocol_q;
	logic                       last_q;

	always_comb begin
		for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
			rsum_c[kr] = '0;
			for (int j = 0; j < c2d_pkg::MAX_KERNEL; j++) begin
				rsum_c[kr] = rsum_c[kr] + prod_s3[kr][j];
			end
		end
		total_c = '0;
		for (int kr = 0; kr < c2d_pkg::MAX_KERNEL; kr++) begin
			total_c = total_c + rsum_s4[kr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsum_s4 <= rsum_c;
			sum_q   <= total_c;
			orow_q  <= orow_s4;
			ocol_q  <= ocol_s4;
			last_q  <= last_s4;
		end
	end

	// holding register for a result that was not taken
	logic [c2d_pkg::DATA_W-1:0] skid_sum_q;
	logic [c2d_pkg::ROW_W-1:0]  skid_row_q;
	logic [c2d_pkg::COL_W-1:0]  skid_col_q;
	logic                       skid_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (out_v_q && !result.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && out_v_q && !result.ready) begin
			skid_sum_q  <= sum_q;
			skid_row_q  <= orow_q;
			skid_col_q  <= ocol_q;
			skid_last_q <= last_q;
		end
	end

	assign result.valid       = skid_v_q || out_v_q;
	assign result.conv_sum    = skid_v_q ? skid_sum_q  : sum_q;
	assign result.out_row     = skid_v_q ? skid_row_q  : orow_q;
	assign result.out_col     = skid_v_q ? skid_col_q  : ocol_q;
	assign result.last_result = skid_v_q ? skid_last_q : last_q;

endmodule

`default_nettype wire

@@ rtl/c2d_checker.sv @@
// ----------------------------------------------------------------------------
// c2d_checker
// Port-level checks on the convolution core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [c2d_pkg::DATA_W-1:0]  res_sum,
	input logic [c2d_pkg::ROW_W-1:0]   res_row,
	input logic [c2d_pkg::COL_W-1:0]   res_col,
	input logic                        res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_sum) && $stable(res_row)
		&& $stable(res_col) && $stable(res_last))
		else $error("result payload changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid)
		else $error("input stalled without a waiting result");

	a_no_result_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result present right after reset");

endmodule

bind conv2d_valid_stride1_core c2d_checker u_c2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (stream.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_sum   (result.conv_sum),
	.res_row   (result.out_row),
	.res_col   (result.out_col),
	.res_last  (result.last_result)
);

`default_nettype wire
